/* hw/rtl/fader_spike_reject_average_defines.svh */
// ----------------------------------------------------------------------------
// Fader spike-reject average: assertion macros
// Shared assertion wrappers for the checker of the fader filter.
// ----------------------------------------------------------------------------
`ifndef FADER_SPIKE_REJECT_AVERAGE_DEFINES_SVH
`define FADER_SPIKE_REJECT_AVERAGE_DEFINES_SVH

// Assertion that is checked only while reset is low.
`define FSRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked across reset.
`define FSRA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/fsra_pkg.sv */
// ----------------------------------------------------------------------------
// Fader spike-reject average: package
// Sizes, register codes, shared types and the window average function.
// ----------------------------------------------------------------------------
package fsra_pkg;

  localparam int FADERS  = 16;
  localparam int SAMPLES = 8;

  localparam int CH_W    = 4;
  localparam int SMP_W   = 8;
  localparam int CFG_W   = 8;
  localparam int SLOT_W  = $clog2(SAMPLES);
  localparam int ROW_W   = (FADERS > 1) ? $clog2(FADERS) : 1;
  localparam int SUM_W   = SMP_W + SLOT_W;
  localparam int WIN_W   = SAMPLES * SMP_W;

  // Reciprocal for the window average: exact floor(sum / SAMPLES) for every
  // sum below 2**SUM_W.
  localparam int DIV_K   = SUM_W + SLOT_W;
  localparam int DIV_M   = (1 << DIV_K) / SAMPLES + 1;
  localparam int DIV_M_W = SUM_W + 1;

  localparam logic [SMP_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [CFG_W-1:0] SPIKE_LIMIT_RST = 8'd50;
  localparam logic [CFG_W-1:0] LOW_SNAP_RST    = 8'd3;
  localparam logic [CFG_W-1:0] HIGH_SNAP_RST   = 8'd252;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SPIKE_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_SNAP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_SNAP   = 2'd2;

  typedef logic [WIN_W-1:0]  row_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [SMP_W-1:0]  smp_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ROW_W-1:0]  ridx_t;

  typedef struct packed {
    logic [CFG_W-1:0] spike_limit;
    logic [CFG_W-1:0] low_snap;
    logic [CFG_W-1:0] high_snap;
  } cfg_t;

  typedef struct packed {
    row_t row;
    sum_t sum;
    smp_t level;
  } calc_t;

  function automatic smp_t window_avg(input sum_t sum);
    logic [SUM_W+DIV_M_W-1:0] prod;
    prod = (SUM_W+DIV_M_W)'(sum) * (SUM_W+DIV_M_W)'(DIV_M);
    return prod[DIV_K +: SMP_W];
  endfunction

endpackage

/* hw/rtl/fsra_window.sv */
// ----------------------------------------------------------------------------
// Fader spike-reject average: sample window store
// One row of SAMPLES samples per fader, registered read, per-row valid bits
// so that a row never written since reset reads as zeros.
// ----------------------------------------------------------------------------
module fsra_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  fsra_pkg::ridx_t rd_addr,
  output fsra_pkg::row_t  rd_row,
  input  logic          wr_en,
  input  fsra_pkg::ridx_t wr_addr,
  input  fsra_pkg::row_t  wr_row
);
  import fsra_pkg::*;

  row_t              mem [FADERS];
  logic [FADERS-1:0] row_vld;
  row_t              rd_q;
  logic              rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_q ? rd_q : '0;

endmodule

/* hw/rtl/fsra_level_calc.sv */
// ----------------------------------------------------------------------------
// Fader spike-reject average: level calculation
// Spike rejection against the previous slot, ring window update, running
// sum, average and snapping near zero and full scale.
// ----------------------------------------------------------------------------
module fsra_level_calc (
  input  fsra_pkg::cfg_t  cfg,
  input  fsra_pkg::row_t  row,
  input  fsra_pkg::sum_t  sum,
  input  fsra_pkg::slot_t slot,
  input  fsra_pkg::smp_t  sample,
  input  logic            init,
  output fsra_pkg::calc_t res
);
  import fsra_pkg::*;

  slot_t prev;
  smp_t  pre;
  smp_t  old;
  smp_t  diff;
  smp_t  stored;
  smp_t  avg;
  smp_t  snapped;
  row_t  row_next;
  sum_t  sum_next;

  always_comb begin
    prev = (slot == '0) ? SLOT_W'(SAMPLES - 1) : slot - 1'b1;
    pre  = row[int'(prev) * SMP_W +: SMP_W];
    old  = row[int'(slot) * SMP_W +: SMP_W];
    diff = (sample > pre) ? sample - pre : pre - sample;

    // Unless init is set, a jump beyond the limit repeats the previous sample instead.
    stored = (!init && (diff > cfg.spike_limit)) ? pre : sample;

    for (int i = 0; i < SAMPLES; i++) begin
      row_next[i*SMP_W +: SMP_W] = (slot == SLOT_W'(i)) ? stored : row[i*SMP_W +: SMP_W];
    end

    sum_next = sum - sum_t'(old) + sum_t'(stored);
    avg      = window_avg(sum_next);

    // Low snap first, then high snap on the already snapped value.
    snapped = (avg < cfg.low_snap) ? '0 : avg;
    if (snapped > cfg.high_snap) begin
      snapped = FULL_SCALE;
    end

    res.row   = row_next;
    res.sum   = sum_next;
    res.level = snapped;
  end

endmodule

/* hw/rtl/fader_spike_reject_average.sv */
// ----------------------------------------------------------------------------
// Fader spike-reject average: top level
// Per-fader moving average with spike rejection and snapping of the ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid/in_ready) carry one 8-bit sample for one
//   fader channel; faders are swept 0 to FADERS-1 and the ring slot moves on
//   after the last fader. Output transactions (out_valid/out_ready) carry the
//   channel, its snapped window average and a changed flag, one per input.
//   The user writes the three settings on the cfg port while the block is
//   idle; the block itself does not enforce this. The row store is read at
//   the accepting edge into the input stage. When that stage advances, the
//   row, running sum and held level of an in-range fader are updated and
//   the output register loads, which raises out_valid.
//   Throughput is one transaction per cycle unless the receiver stalls; the
//   row store is read and written once per cycle, and a write-to-read bypass
//   covers a fader that repeats in consecutive transactions.
//   Reset clears the windows at once through per-row valid bits, with no
//   clearing pass, resets the sums, held levels and slot, and restores the settings.
//   When the receiver stalls, the result holds in the output register, one
//   further transaction waits in the input stage, and then in_ready drops.
// ----------------------------------------------------------------------------
module fader_spike_reject_average (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [fsra_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [fsra_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fsra_pkg::CH_W-1:0]       channel,
  input  logic [fsra_pkg::SMP_W-1:0]      sample,
  input  logic                            init,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fsra_pkg::CH_W-1:0]       out_channel,
  output logic [fsra_pkg::SMP_W-1:0]      level,
  output logic                            changed
);
  import fsra_pkg::*;

  cfg_t              cfg;
  logic              s1_valid;
  logic [CH_W-1:0]   s1_channel;
  smp_t              s1_sample;
  logic              s1_init;
  slot_t             write_slot;
  slot_t             write_slot_next;
  sum_t              sums [FADERS];
  smp_t              held [FADERS];
  logic              byp_valid;
  ridx_t             byp_idx;
  row_t              byp_row;

  logic              accept;
  logic              adv;
  logic              commit;
  logic              s1_in_range;
  ridx_t             s1_idx;
  row_t              mem_row;
  row_t              row_cur;
  calc_t             calc;
  logic              lvl_changed;

  assign accept      = in_valid && in_ready;
  assign adv         = s1_valid && (!out_valid || out_ready);
  assign in_ready    = !s1_valid || adv;
  assign s1_in_range = (CH_W + 1)'(s1_channel) < (CH_W + 1)'(FADERS);
  assign s1_idx      = s1_channel[ROW_W-1:0];
  assign commit      = adv && s1_in_range;

  // The bypass row is always the latest write, so it matches the store.
  assign row_cur     = (byp_valid && (byp_idx == s1_idx)) ? byp_row : mem_row;
  assign lvl_changed = held[s1_idx] != calc.level;
  assign write_slot_next = (write_slot == SLOT_W'(SAMPLES - 1)) ? '0 : write_slot + 1'b1;

  fsra_window u_window (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (channel[ROW_W-1:0]),
    .rd_row  (mem_row),
    .wr_en   (commit),
    .wr_addr (s1_idx),
    .wr_row  (calc.row)
  );

  fsra_level_calc u_calc (
    .cfg    (cfg),
    .row    (row_cur),
    .sum    (sums[s1_idx]),
    .slot   (write_slot),
    .sample (s1_sample),
    .init   (s1_init),
    .res    (calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spike_limit <= SPIKE_LIMIT_RST;
      cfg.low_snap    <= LOW_SNAP_RST;
      cfg.high_snap   <= HIGH_SNAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPIKE_LIMIT: cfg.spike_limit <= cfg_wdata;
        REG_LOW_SNAP:    cfg.low_snap    <= cfg_wdata;
        REG_HIGH_SNAP:   cfg.high_snap   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      write_slot <= '0;
      byp_valid  <= 1'b0;
      for (int i = 0; i < FADERS; i++) begin
        sums[i] <= '0;
        held[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end

      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (commit) begin
        sums[s1_idx] <= calc.sum;
        held[s1_idx] <= calc.level;
        byp_valid    <= 1'b1;
        if (s1_channel == CH_W'(FADERS - 1)) begin
          write_slot <= write_slot_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_channel <= channel;
      s1_sample  <= sample;
      s1_init    <= init;
    end
    if (commit) begin
      byp_idx <= s1_idx;
      byp_row <= calc.row;
    end
    if (adv) begin
      out_channel <= s1_channel;
      level       <= s1_in_range ? calc.level : '0;
      changed     <= s1_in_range && lvl_changed;
    end
  end

endmodule

/* hw/rtl/fsra_checker.sv */
// ----------------------------------------------------------------------------
// Fader spike-reject average: port checker
// Watches the top-level ports for handshake and latency behavior.
// ----------------------------------------------------------------------------
`include "fader_spike_reject_average_defines.svh"

module fsra_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fsra_pkg::CH_W-1:0]      out_channel,
  input logic [fsra_pkg::SMP_W-1:0]     level,
  input logic                           changed
);

  // A stalled result must hold its payload.
  `FSRA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(level) && $stable(changed), "stalled result changed")

  // Nothing is reported in the cycle after a reset cycle.
  `FSRA_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result present after reset")

  // With the output register empty the block must take input.
  `FSRA_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")

  // An accepted transaction reaches the output when the receiver keeps taking results.
  `FSRA_ASSERT(a_latency, (in_valid && in_ready) ##1 out_ready |=> out_valid, "result late")

endmodule

bind fader_spike_reject_average fsra_checker u_fsra_checker (.*);

/* sim/tb_fader_spike_reject_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fader spike-reject average: testbench
// A short table of directed samples is followed by phases of random samples
// and fader sweeps, each phase under its own filter settings. Each result is
// checked against a typed row's value or a model of windows, sums and held levels.
// ----------------------------------------------------------------------------
module tb_fader_spike_reject_average;
  import fsra_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic {ROW_SAMPLE, ROW_SETTINGS} row_kind_e;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] lvl;
    logic             chg;
  } level_rec_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] smp;
    logic             ini;
    logic             typed;
    level_rec_t       want;
    cfg_t             cfg;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_SPIKE_LIMIT;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      channel = '0;
  logic [SMP_W-1:0]     sample = '0;
  logic                 init = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      out_channel;
  logic [SMP_W-1:0]     level;
  logic                 changed;

  // Local copy of the filter state and settings.
  smp_t  fader_window [FADERS][SAMPLES];
  sum_t  fader_sum [FADERS];
  smp_t  fader_held [FADERS];
  slot_t ring_slot;
  cfg_t  settings;

  int         target [FADERS];
  level_rec_t expected_levels [$];
  stim_row_t  directed_rows [$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         quiet = 1'b0;

  fader_spike_reject_average dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .channel     (channel),
    .sample      (sample),
    .init        (init),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .level       (level),
    .changed     (changed)
  );

  always #2 clk = ~clk;

  function automatic level_rec_t filter_sample(input logic [CH_W-1:0] ch, input smp_t smp,
                                               input logic ini);
    level_rec_t     rec;
    slot_t          prev_slot;
    smp_t           prev_smp;
    smp_t           kept;
    logic [SMP_W:0] jump;
    int             avg;
    rec.ch  = ch;
    rec.lvl = '0;
    rec.chg = 1'b0;
    if (int'(ch) >= FADERS) return rec;
    // The previous sample is the entry one slot back, not the last write.
    prev_slot = (ring_slot == 0) ? slot_t'(SAMPLES - 1) : ring_slot - 1'b1;
    prev_smp  = fader_window[ch][prev_slot];
    kept      = smp;
    if (!ini) begin
      jump = (smp > prev_smp) ? smp - prev_smp : prev_smp - smp;
      if (jump > settings.spike_limit) kept = prev_smp;
    end
    fader_sum[ch] = fader_sum[ch] - fader_window[ch][ring_slot] + kept;
    fader_window[ch][ring_slot] = kept;
    avg = int'(fader_sum[ch]) / SAMPLES;
    if (avg < int'(settings.low_snap)) avg = 0;
    if (avg > int'(settings.high_snap)) avg = int'(FULL_SCALE);
    rec.lvl = smp_t'(avg);
    rec.chg = (fader_held[ch] != rec.lvl);
    fader_held[ch] = rec.lvl;
    if (int'(ch) == FADERS - 1)
      ring_slot = (int'(ring_slot) == SAMPLES - 1) ? '0 : ring_slot + 1'b1;
    return rec;
  endfunction

  // Drifting level per fader with occasional jumps and wild spikes.
  function automatic smp_t pick_sample(input int ch);
    int r;
    int v;
    r = $urandom_range(0, 15);
    if (r == 0) return smp_t'($urandom_range(0, 255));
    if (r == 1) target[ch] = ($urandom_range(0, 1) == 1) ? 255 : 0;
    else target[ch] = target[ch] + int'($urandom_range(0, 16)) - 8;
    if (target[ch] < 0) target[ch] = 0;
    if (target[ch] > 255) target[ch] = 255;
    v = target[ch] + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return smp_t'(v);
  endfunction

  task automatic add_sample(input int ch, input int smp, input bit ini, input bit typed,
                            input int lvl, input bit chg);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_SAMPLE;
    row.ch       = CH_W'(ch);
    row.smp      = SMP_W'(smp);
    row.ini      = ini;
    row.typed    = typed;
    row.want.ch  = CH_W'(ch);
    row.want.lvl = SMP_W'(lvl);
    row.want.chg = chg;
    directed_rows.push_back(row);
  endtask

  task automatic add_settings(input int sl, input int ls, input int hs);
    stim_row_t row;
    row                 = '0;
    row.kind            = ROW_SETTINGS;
    row.cfg.spike_limit = CFG_W'(sl);
    row.cfg.low_snap    = CFG_W'(ls);
    row.cfg.high_snap   = CFG_W'(hs);
    directed_rows.push_back(row);
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input smp_t smp, input logic ini,
                             input logic typed, input level_rec_t want);
    level_rec_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= smp;
    init     <= ini;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = filter_sample(ch, smp, ini);
    expected_levels.push_back(typed ? want : predicted);
  endtask

  task automatic offer_sample(input bit gaps, input int ch, input int smp, input bit ini);
    int n;
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    send_sample(CH_W'(ch), SMP_W'(smp), ini, 1'b0, '0);
  endtask

  task automatic wait_for_levels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(input cfg_t c);
    wait_for_levels();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPIKE_LIMIT;
    cfg_wdata <= c.spike_limit;
    @(negedge clk);
    cfg_index <= REG_LOW_SNAP;
    cfg_wdata <= c.low_snap;
    @(negedge clk);
    cfg_index <= REG_HIGH_SNAP;
    cfg_wdata <= c.high_snap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings = c;
  endtask

  task automatic run_phase(input int items);
    int sent;
    int mode;
    int r;
    bit gaps;
    bit ini;
    sent = 0;
    while (sent < items) begin
      mode = $urandom_range(0, 9);
      gaps = ($urandom_range(0, 2) != 0);
      ini  = ($urandom_range(0, 7) == 0);
      if (mode == 0) begin
        offer_sample(gaps, $urandom_range(0, 15), $urandom_range(0, 255),
                     ($urandom_range(0, 1) == 1));
        sent++;
      end else if (mode == 1) begin
        // Sweep with skipped and repeated faders.
        for (int c = 0; c < FADERS; c++) begin
          r = $urandom_range(0, 5);
          if (r != 0) begin
            offer_sample(gaps, c, pick_sample(c), ini);
            sent++;
          end
          if (r == 1) begin
            offer_sample(gaps, c, pick_sample(c), ini);
            sent++;
          end
        end
      end else begin
        for (int c = 0; c < FADERS; c++) begin
          offer_sample(gaps, c, pick_sample(c), ini);
          sent++;
        end
      end
    end
  endtask

  initial begin
    stim_row_t row;
    cfg_t      next_cfg;
    foreach (fader_window[f, s]) fader_window[f][s] = '0;
    foreach (fader_sum[f]) begin
      fader_sum[f]  = '0;
      fader_held[f] = '0;
      target[f]     = $urandom_range(0, 255);
    end
    ring_slot            = '0;
    settings.spike_limit = SPIKE_LIMIT_RST;
    settings.low_snap    = LOW_SNAP_RST;
    settings.high_snap   = HIGH_SNAP_RST;

    add_sample(0, 0, 0, 1, 0, 0);
    add_sample(1, 255, 0, 1, 0, 0);
    add_sample(1, 50, 0, 0, 0, 0);
    add_sample(1, 51, 0, 0, 0, 0);
    add_sample(2, 255, 1, 1, 31, 1);
    // Fill the last fader's window so the slot wraps.
    for (int k = 0; k < SAMPLES - 1; k++) add_sample(15, 255, 1, 0, 0, 0);
    add_sample(15, 255, 1, 1, 255, 1);
    add_sample(15, 0, 0, 1, 255, 0);
    add_sample(14, 2, 0, 0, 0, 0);
    add_settings(255, LOW_SNAP_RST, HIGH_SNAP_RST);
    add_sample(3, 255, 0, 0, 0, 0);
    // Crossed snap points: the low snap acts first.
    add_settings(255, 255, 0);
    add_sample(3, 200, 0, 0, 0, 0);
    add_sample(15, 255, 0, 0, 0, 0);
    add_settings(0, 0, 255);
    add_sample(0, 1, 0, 0, 0, 0);
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(4, 128, 1, 0, 0, 0);
    add_sample(5, 3, 0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_SETTINGS) program_settings(row.cfg);
      else send_sample(row.ch, row.smp, row.ini, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          next_cfg.spike_limit = SPIKE_LIMIT_RST;
          next_cfg.low_snap    = LOW_SNAP_RST;
          next_cfg.high_snap   = HIGH_SNAP_RST;
        end
        1: begin
          next_cfg.spike_limit = 8'd0;
          next_cfg.low_snap    = 8'd0;
          next_cfg.high_snap   = 8'd255;
        end
        2: begin
          next_cfg.spike_limit = 8'd255;
          next_cfg.low_snap    = 8'd255;
          next_cfg.high_snap   = 8'd0;
        end
        default: begin
          next_cfg.spike_limit = CFG_W'($urandom_range(0, 80));
          next_cfg.low_snap    = CFG_W'($urandom_range(0, 12));
          next_cfg.high_snap   = CFG_W'($urandom_range(240, 255));
        end
      endcase
      quiet = (p == PHASES - 1);
      program_settings(next_cfg);
      run_phase(PHASE_ITEMS);
    end

    wait_for_levels();
    if (error_count == 0) begin
      $display("fader_spike_reject_average: match");
    end else begin
      $display("fader_spike_reject_average: mismatch");
    end
    $finish;
  end

  // Receiver: random stall bursts and ready stretches, always ready at the end.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        n = quiet ? 0 : $urandom_range(0, 20);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12) - 1;
      end
      for (int k = 0; k < n && !quiet; k++) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    level_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $error("result transaction with nothing expected, out_channel %0d", out_channel);
        error_count++;
      end else begin
        want = expected_levels.pop_front();
        if (out_channel !== want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, out_channel);
          error_count++;
        end
        if (level !== want.lvl) begin
          $error("level: expected %0d, got %0d", want.lvl, level);
          error_count++;
        end
        if (changed !== want.chg) begin
          $error("changed: expected %0d, got %0d", want.chg, changed);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fader_spike_reject_average: mismatch");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fsra_pkg.sv
hw/rtl/fsra_window.sv
hw/rtl/fsra_level_calc.sv
hw/rtl/fader_spike_reject_average.sv
hw/rtl/fsra_checker.sv
sim/tb_fader_spike_reject_average.sv
